// ===== rtl/cvs_pkg.sv =====
// ----------------------------------------------------------------------------
// Cookie value scanner package
// Beat types, character codes, register indexes and segment phases shared by
// the scanner modules.
// ----------------------------------------------------------------------------
package cvs_pkg;

	localparam int unsigned OUT_BITS = 16;
	localparam int unsigned LEN_BITS = 5;
	localparam int unsigned CFG_BITS = 64;
	localparam int unsigned CFG_INDEX_BITS = 2;
	localparam int unsigned NAME_SLOTS = 16;

	localparam logic [7:0] CH_DELIM  = 8'h3B;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_EQUALS = 8'h3D;

	localparam logic [CFG_INDEX_BITS-1:0] REG_NAME_LOW    = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_NAME_HIGH   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_NAME_LENGTH = 2'd2;

	typedef enum logic [2:0] {
		PH_LEADING = 3'd0,
		PH_NAME    = 3'd1,
		PH_EQUALS  = 3'd2,
		PH_VALUE   = 3'd3,
		PH_SKIP    = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] header_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic                value_found;
		logic [OUT_BITS-1:0] value_offset;
		logic [OUT_BITS-1:0] value_length;
		logic                field_done;
		logic                name_error;
	} out_beat_t;

endpackage

// ===== rtl/cvs_step.sv =====
// ----------------------------------------------------------------------------
// Cookie value scanner step logic
// Next segment state and the optional result for one header byte.
// ----------------------------------------------------------------------------
module cvs_step #(
	parameter int unsigned MAX_NAME_BYTES = 16,
	parameter int unsigned POSITION_BITS = 16
) (
	input  cvs_pkg::phase_t                              phase,
	input  logic [$clog2(MAX_NAME_BYTES+1)-1:0]          match_count,
	input  logic [POSITION_BITS-1:0]                     value_begin,
	input  logic [POSITION_BITS-1:0]                     byte_position,
	input  cvs_pkg::in_beat_t                            beat,
	input  logic [cvs_pkg::NAME_SLOTS-1:0][7:0]          name_bytes,
	input  logic [cvs_pkg::LEN_BITS-1:0]                 name_length,
	output cvs_pkg::phase_t                              phase_next,
	output logic [$clog2(MAX_NAME_BYTES+1)-1:0]          match_next,
	output logic [POSITION_BITS-1:0]                     value_begin_next,
	output logic [POSITION_BITS-1:0]                     byte_position_next,
	output logic                                         emit,
	output cvs_pkg::out_beat_t                           result
);
	import cvs_pkg::*;

	localparam int unsigned MatchW = $clog2(MAX_NAME_BYTES + 1);
	localparam int unsigned ExtW = (POSITION_BITS > OUT_BITS) ? POSITION_BITS : OUT_BITS;
	localparam logic [MatchW-1:0] MaxCount = MatchW'(MAX_NAME_BYTES);
	localparam logic [POSITION_BITS-1:0] PosMax = '1;
	localparam logic [ExtW-1:0] OutMax = ExtW'({OUT_BITS{1'b1}});

	logic [7:0]               ch;
	logic                     delim;
	logic                     white;
	logic [MatchW-1:0]        eff_len;
	logic [POSITION_BITS-1:0] pos_inc;
	logic [POSITION_BITS-1:0] seg_end;
	logic [POSITION_BITS-1:0] vlen;
	logic [ExtW-1:0]          off_ext;
	logic [ExtW-1:0]          len_ext;
	phase_t                   phase_a;
	logic [MatchW-1:0]        match_a;
	logic [POSITION_BITS-1:0] vbegin_a;
	logic                     found;

	always_comb begin
		ch = beat.header_byte;
		delim = (ch == CH_DELIM);
		white = (ch == CH_SPACE) || (ch == CH_TAB);
		eff_len = (name_length > LEN_BITS'(MAX_NAME_BYTES)) ? MaxCount : MatchW'(name_length);
		pos_inc = (byte_position == PosMax) ? byte_position : byte_position + 1'b1;
		phase_a = phase;
		match_a = match_count;
		vbegin_a = value_begin;
		if (!delim) begin
			if (phase_a == PH_LEADING && !white) begin
				phase_a = PH_NAME;
			end
			if (phase_a == PH_NAME) begin
				if (match_count >= MaxCount || eff_len == '0 ||
				    ch != name_bytes[4'(match_count)]) begin
					phase_a = PH_SKIP;
				end else begin
					match_a = match_count + 1'b1;
					if (match_a >= eff_len) begin
						phase_a = PH_EQUALS;
					end
				end
			end else if (phase_a == PH_EQUALS) begin
				if (ch == CH_EQUALS) begin
					phase_a = PH_VALUE;
					vbegin_a = pos_inc;
				end else begin
					phase_a = PH_SKIP;
				end
			end
		end
		found = (phase_a == PH_VALUE) && (eff_len != '0);
		seg_end = delim ? byte_position : pos_inc;
		vlen = (seg_end >= vbegin_a) ? seg_end - vbegin_a : '0;
		off_ext = found ? ExtW'(vbegin_a) : '0;
		len_ext = found ? ExtW'(vlen) : '0;
		emit = (delim || beat.last_byte) && (found || beat.last_byte);
		result.value_found = found;
		result.value_offset = (off_ext > OutMax) ? OutMax[OUT_BITS-1:0] : off_ext[OUT_BITS-1:0];
		result.value_length = (len_ext > OutMax) ? OutMax[OUT_BITS-1:0] : len_ext[OUT_BITS-1:0];
		result.field_done = beat.last_byte;
		result.name_error = beat.last_byte && (eff_len == '0);
		if (delim || beat.last_byte) begin
			phase_next = PH_LEADING;
			match_next = '0;
			value_begin_next = '0;
		end else begin
			phase_next = phase_a;
			match_next = match_a;
			value_begin_next = vbegin_a;
		end
		byte_position_next = beat.last_byte ? '0 : pos_inc;
	end

endmodule

// ===== rtl/cookie_value_scanner_core.sv =====
// ----------------------------------------------------------------------------
// Cookie value scanner core
// Scans a Cookie header one byte per beat and reports the offset and length
// of the value of the configured cookie name.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                      Beat
//  in       in_valid/in_ready/in_data    one header byte, last-byte flag
//  out      out_valid/out_ready/out_data one result per match or field end
//  cfg      cfg_write/cfg_index/cfg_data one register write, no handshake
//
// Each taken byte's result, if any, appears in the result register on the
// next cycle. One byte per cycle is sustained while out_ready is high.
// A result waiting in the output register does not stop input while the
// output side takes it in the same cycle.
// Reset clears the segment state, byte position, out_valid and name bytes,
// and sets the name length to one; the result register is not reset.
module cookie_value_scanner_core #(
	parameter int unsigned MAX_NAME_BYTES = 16,
	parameter int unsigned POSITION_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  cvs_pkg::in_beat_t                      in_data,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output cvs_pkg::out_beat_t                     out_data,
	input  logic                                   cfg_write,
	input  logic [cvs_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [cvs_pkg::CFG_BITS-1:0]           cfg_data
);
	import cvs_pkg::*;

	localparam int unsigned MatchW = $clog2(MAX_NAME_BYTES + 1);

	logic [CFG_BITS-1:0]      name_low_q;
	logic [CFG_BITS-1:0]      name_high_q;
	logic [LEN_BITS-1:0]      name_length_q;
	phase_t                   phase_q;
	logic [MatchW-1:0]        match_q;
	logic [POSITION_BITS-1:0] vbegin_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic                     out_valid_q;
	out_beat_t                res_q;

	phase_t                   phase_next;
	logic [MatchW-1:0]        match_next;
	logic [POSITION_BITS-1:0] vbegin_next;
	logic [POSITION_BITS-1:0] pos_next;
	logic                     emit;
	out_beat_t                result;
	logic                     in_fire;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = res_q;

	cvs_step #(
		.MAX_NAME_BYTES(MAX_NAME_BYTES),
		.POSITION_BITS(POSITION_BITS)
	) u_step (
		.phase(phase_q),
		.match_count(match_q),
		.value_begin(vbegin_q),
		.byte_position(pos_q),
		.beat(in_data),
		.name_bytes({name_high_q, name_low_q}),
		.name_length(name_length_q),
		.phase_next(phase_next),
		.match_next(match_next),
		.value_begin_next(vbegin_next),
		.byte_position_next(pos_next),
		.emit(emit),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_low_q <= '0;
			name_high_q <= '0;
			name_length_q <= LEN_BITS'(1);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_NAME_LOW: name_low_q <= cfg_data;
				REG_NAME_HIGH: name_high_q <= cfg_data;
				REG_NAME_LENGTH: name_length_q <= cfg_data[LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEADING;
			match_q <= '0;
			vbegin_q <= '0;
			pos_q <= '0;
		end else if (in_fire) begin
			phase_q <= phase_next;
			match_q <= match_next;
			vbegin_q <= vbegin_next;
			pos_q <= pos_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			res_q <= result;
		end
	end

`ifndef SYNTHESIS
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_data.last_byte |=>
			pos_q == '0 && phase_q == PH_LEADING && match_q == '0)
		else $error("segment state not cleared after the last byte");

	a_last_reports: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_data.last_byte |=> out_valid && out_data.field_done)
		else $error("last byte gave no closing result");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.name_error |->
			out_data.field_done && !out_data.value_found)
		else $error("name error result is malformed");

	a_match_bound: assert property (@(posedge clk) disable iff (!arst_n)
		match_q <= MatchW'(MAX_NAME_BYTES))
		else $error("match count beyond the name capacity");
`endif

endmodule
